/* rtl/psf_pkg.sv */
// ----------------------------------------------------------------------------
// Plucked-string filter package
// Shared widths, register indexes, reset values and interface types.
// ----------------------------------------------------------------------------
package psf_pkg;

    // Sample and coefficient widths
    localparam int SAMPLE_BITS = 16;
    localparam int DELAY_W     = 13;
    localparam int GAIN_W      = 16;
    localparam int COEF_W      = 17;

    // Comb and lowpass values carry two guard bits over a sample.
    localparam int G_W    = SAMPLE_BITS + 2;
    // Multiplicand of the serial multiplier: a delay-line sample or lowpass minus previous output.
    localparam int DIFF_W = G_W + 1;
    // Rounded product width.
    localparam int RND_W  = DIFF_W + 2;

    // Configuration port
    localparam int CFG_W      = 17;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COMB_GAIN    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALLPASS_COEF = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 13'd100;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd65000;
    localparam logic [COEF_W-1:0]  COEF_RESET  = 17'd32768;
    localparam logic [COEF_W-1:0]  COEF_ONE    = 17'd65536;

    localparam int MAX_DELAY_DEF = 4096;

    // Item kinds carried in tuser
    localparam logic MODE_PROCESS = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    // Control from the sequencer to the delay line
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } psf_dl_ctrl_t;

endpackage

/* rtl/psf_serial_mult.sv */
// ----------------------------------------------------------------------------
// Plucked-string filter serial multiplier
// Signed by unsigned shift-add multiplier, one multiplier bit per cycle,
// with Q1.16 round-half-up on the product.
// ----------------------------------------------------------------------------
module psf_serial_mult (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [psf_pkg::DIFF_W-1:0]   mcand,
    input  logic        [psf_pkg::COEF_W-1:0]   mplier,
    output logic                                done,
    output logic signed [psf_pkg::RND_W-1:0]    result
);

    localparam int AW    = psf_pkg::DIFF_W + 1;
    localparam int NW    = psf_pkg::COEF_W;
    localparam int CNT_W = $clog2(NW);

    logic signed [AW-1:0]              acc_reg;
    logic        [NW-1:0]              lo_reg;
    logic signed [psf_pkg::DIFF_W-1:0] mcand_reg;
    logic        [NW-1:0]              mplier_reg;
    logic        [CNT_W-1:0]           cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;

    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] sum;

    assign addend = mplier_reg[0] ? {mcand_reg[psf_pkg::DIFF_W-1], mcand_reg} : '0;
    assign sum    = acc_reg + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The partial sum shifts right each step; its low bit drops into lo_reg.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            lo_reg     <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg    <= {sum[AW-1], sum[AW-1:1]};
            lo_reg     <= {sum[0], lo_reg[NW-1:1]};
            mplier_reg <= {1'b0, mplier_reg[NW-1:1]};
        end
    end

    // Product is {acc, lo}; adding 2^15 and flooring by 2^16 keeps acc and
    // the top low bit, plus the next low bit as the rounding carry.
    assign result = $signed({acc_reg, lo_reg[NW-1]})
                  + $signed({{(psf_pkg::RND_W-1){1'b0}}, lo_reg[NW-2]});
    assign done   = done_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("multiplier did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");
`endif

endmodule

/* rtl/psf_delay_line.sv */
// ----------------------------------------------------------------------------
// Plucked-string filter delay line
// Circular history of past outputs with a fill count, so that slots not yet
// written since reset or restart read as zero.
// ----------------------------------------------------------------------------
module psf_delay_line #(
    parameter int MAX_DELAY = psf_pkg::MAX_DELAY_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  psf_pkg::psf_dl_ctrl_t                   ctrl,
    input  logic        [psf_pkg::DELAY_W-1:0]      delay_length,
    input  logic signed [psf_pkg::SAMPLE_BITS-1:0]  wr_data,
    output logic signed [psf_pkg::SAMPLE_BITS-1:0]  rd_data
);

    localparam int PW = $clog2(MAX_DELAY);
    localparam int CW = $clog2(MAX_DELAY + 1);
    localparam int EW = (CW > psf_pkg::DELAY_W) ? CW : psf_pkg::DELAY_W;

    logic signed [psf_pkg::SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic signed [psf_pkg::SAMPLE_BITS-1:0] mem_q_reg;
    logic        [PW-1:0]                   ptr_reg;
    logic        [CW-1:0]                   fill_reg;
    logic                                   hit_reg;

    logic [EW-1:0] len_ext;
    logic [EW-1:0] len_eff;
    logic [CW-1:0] len_c;
    logic [CW:0]   ptr_w;
    logic [CW:0]   len_w;
    logic [CW:0]   rd_sum;
    logic [PW-1:0] rd_addr;
    logic          hit;

    // A zero length acts as one, and a length past the store acts as its depth.
    assign len_ext = EW'(delay_length);
    always_comb
    begin
        if (len_ext == '0)
            len_eff = EW'(1);
        else if (len_ext > EW'(MAX_DELAY))
            len_eff = EW'(MAX_DELAY);
        else
            len_eff = len_ext;
    end
    assign len_c = len_eff[CW-1:0];

    assign ptr_w   = (CW+1)'(ptr_reg);
    assign len_w   = (CW+1)'(len_c);
    assign rd_sum  = (ptr_w >= len_w) ? (ptr_w - len_w)
                                      : (ptr_w + (CW+1)'(MAX_DELAY) - len_w);
    assign rd_addr = rd_sum[PW-1:0];

    // The slot L back was written since the last clear only if L <= fill.
    assign hit = (len_c <= fill_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
            mem[ptr_reg] <= wr_data;
        if (ctrl.rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.rd_en)
                hit_reg <= hit;
            if (ctrl.clear)
            begin
                ptr_reg  <= '0;
                fill_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                ptr_reg <= (ptr_reg == PW'(MAX_DELAY - 1)) ? '0 : ptr_reg + 1'b1;
                if (fill_reg != CW'(MAX_DELAY))
                    fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign rd_data = hit_reg ? mem_q_reg : '0;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_DELAY))
        else $error("delay line fill count past depth");

    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en && !ctrl.clear |=> fill_reg != '0)
        else $error("write did not count toward fill");
`endif

endmodule

/* rtl/plucked_string_filter.sv */
// Sample items are taken only in the idle state, once the previous result has
// gone to the output register; each item makes two 17-step passes of the shared
// serial multiplier. A restart item gives no result.
// Reset loads the register defaults and empties the delay line at once
// through its fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Plucked-string filter top level
// Comb, two-tap lowpass and allpass stages sequenced over a serial multiplier.
// ----------------------------------------------------------------------------
module plucked_string_filter #(
    parameter int MAX_DELAY = psf_pkg::MAX_DELAY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration
    input  logic                                cfg_we,
    input  logic [psf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [psf_pkg::CFG_W-1:0]           cfg_wdata,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [psf_pkg::SAMPLE_BITS-1:0]     s_tdata,   // [15:0] sample_in
    input  logic                                s_tuser,   // [0] mode
    // Output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [psf_pkg::SAMPLE_BITS-1:0]     m_tdata    // [15:0] sample_out
);

    localparam int SB  = psf_pkg::SAMPLE_BITS;
    localparam int GW  = psf_pkg::G_W;
    localparam int DW  = psf_pkg::DIFF_W;
    localparam int RW  = psf_pkg::RND_W;
    localparam int TW  = RW + 1;
    localparam logic signed [TW-1:0] SAT_HI = TW'(2**(SB-1) - 1);
    localparam logic signed [TW-1:0] SAT_LO = -SAT_HI - TW'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_MUL1,
        ST_COMB,
        ST_AVG,
        ST_DIFF,
        ST_MUL2,
        ST_ALLPASS,
        ST_WRITE,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [psf_pkg::DELAY_W-1:0] delay_length_reg;
    logic [psf_pkg::GAIN_W-1:0]  comb_gain_reg;
    logic [psf_pkg::COEF_W-1:0]  allpass_coef_reg;

    logic signed [SB-1:0] x_reg;
    logic signed [GW-1:0] g_reg;
    logic signed [GW-1:0] h_reg;
    logic signed [SB-1:0] y_reg;
    logic signed [GW-1:0] g_prev_reg;
    logic signed [GW-1:0] h_prev_reg;
    logic signed [SB-1:0] y_prev_reg;
    logic                 m_tvalid_reg;
    logic [SB-1:0]        m_tdata_reg;

    logic                   s_accept;
    psf_pkg::psf_dl_ctrl_t  dl_ctrl;
    logic signed [SB-1:0]   dl_rd_data;

    logic                   mult_start;
    logic signed [DW-1:0]   mult_mcand;
    logic [psf_pkg::COEF_W-1:0] mult_mplier;
    logic [psf_pkg::COEF_W-1:0] coef_eff;
    logic                   mult_done;
    logic signed [RW-1:0]   mult_result;

    logic signed [GW-1:0]   g_next;
    logic signed [GW:0]     avg_sum;
    logic signed [DW-1:0]   diff;
    logic signed [TW-1:0]   ap_sum;
    logic signed [SB-1:0]   y_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign dl_ctrl.rd_en = (state_reg == ST_READ);
    assign dl_ctrl.wr_en = (state_reg == ST_WRITE);
    assign dl_ctrl.clear = s_accept && (s_tuser == psf_pkg::MODE_RESTART);

    assign coef_eff = (allpass_coef_reg > psf_pkg::COEF_ONE) ? psf_pkg::COEF_ONE
                                                             : allpass_coef_reg;

    assign diff = {h_reg[GW-1], h_reg} - DW'(y_prev_reg);

    assign mult_start  = (state_reg == ST_FETCH) || (state_reg == ST_DIFF);
    assign mult_mcand  = (state_reg == ST_FETCH) ? DW'(dl_rd_data) : diff;
    assign mult_mplier = (state_reg == ST_FETCH) ? {1'b0, comb_gain_reg} : coef_eff;

    // Comb sum fits the guard bits, so the rounded product is cut to GW bits.
    assign g_next  = GW'(x_reg) + mult_result[GW-1:0];
    assign avg_sum = {g_reg[GW-1], g_reg} + {g_prev_reg[GW-1], g_prev_reg}
                   + (GW+1)'(1);
    assign ap_sum  = TW'(h_prev_reg) + TW'(mult_result);

    always_comb
    begin
        if (ap_sum > SAT_HI)
            y_next = SAT_HI[SB-1:0];
        else if (ap_sum < SAT_LO)
            y_next = SAT_LO[SB-1:0];
        else
            y_next = ap_sum[SB-1:0];
    end

    psf_delay_line #(
        .MAX_DELAY (MAX_DELAY)
    ) u_delay_line (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (dl_ctrl),
        .delay_length (delay_length_reg),
        .wr_data      (y_reg),
        .rd_data      (dl_rd_data)
    );

    psf_serial_mult u_mult (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mult_start),
        .mcand  (mult_mcand),
        .mplier (mult_mplier),
        .done   (mult_done),
        .result (mult_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= psf_pkg::DELAY_RESET;
            comb_gain_reg    <= psf_pkg::GAIN_RESET;
            allpass_coef_reg <= psf_pkg::COEF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                psf_pkg::REG_DELAY_LENGTH:
                    delay_length_reg <= cfg_wdata[psf_pkg::DELAY_W-1:0];
                psf_pkg::REG_COMB_GAIN:
                    comb_gain_reg <= cfg_wdata[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_ALLPASS_COEF:
                    allpass_coef_reg <= cfg_wdata[psf_pkg::COEF_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            x_reg        <= '0;
            g_reg        <= '0;
            h_reg        <= '0;
            y_reg        <= '0;
            g_prev_reg   <= '0;
            h_prev_reg   <= '0;
            y_prev_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // The output state reloads the register itself when it is taken.
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tuser == psf_pkg::MODE_RESTART)
                        begin
                            g_prev_reg <= '0;
                            h_prev_reg <= '0;
                            y_prev_reg <= '0;
                        end
                        else
                        begin
                            x_reg     <= s_tdata;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ:
                    state_reg <= ST_FETCH;
                ST_FETCH:
                    state_reg <= ST_MUL1;
                ST_MUL1:
                begin
                    if (mult_done)
                        state_reg <= ST_COMB;
                end
                ST_COMB:
                begin
                    g_reg     <= g_next;
                    state_reg <= ST_AVG;
                end
                ST_AVG:
                begin
                    h_reg     <= avg_sum[GW:1];
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                    state_reg <= ST_MUL2;
                ST_MUL2:
                begin
                    if (mult_done)
                        state_reg <= ST_ALLPASS;
                end
                ST_ALLPASS:
                begin
                    y_reg     <= y_next;
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    g_prev_reg <= g_reg;
                    h_prev_reg <= h_reg;
                    y_prev_reg <= y_reg;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    // Hand the result over once the output register is free.
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= y_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mult_done |-> (state_reg == ST_MUL1 || state_reg == ST_MUL2))
        else $error("multiplier finished outside a wait state");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tuser == psf_pkg::MODE_RESTART |=>
            g_prev_reg == '0 && h_prev_reg == '0 && y_prev_reg == '0)
        else $error("restart left filter history");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result presented outside the output state");
`endif

endmodule

/* tb/psf_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plucked-string filter scoreboard
// Predicts each output sample of the comb, lowpass and allpass chain and
// checks the block's results against the predictions in order.
// ----------------------------------------------------------------------------
package psf_tb_pkg;

    class string_tone_checker;

        logic [psf_pkg::DELAY_W-1:0]            delay_length;
        logic [psf_pkg::GAIN_W-1:0]             comb_gain;
        logic [psf_pkg::COEF_W-1:0]             allpass_coef;

        logic signed [psf_pkg::SAMPLE_BITS-1:0] string_ring [psf_pkg::MAX_DELAY_DEF];
        int                                     write_slot;
        logic signed [psf_pkg::G_W-1:0]         comb_prev;
        logic signed [psf_pkg::G_W-1:0]         lowpass_prev;
        logic signed [psf_pkg::SAMPLE_BITS-1:0] out_prev;

        logic [psf_pkg::SAMPLE_BITS-1:0]        expected_tone [$];
        int                                     mismatches;
        int                                     samples_taken;
        int                                     restarts_taken;
        int                                     tones_checked;

        function new();
            delay_length   = psf_pkg::DELAY_RESET;
            comb_gain      = psf_pkg::GAIN_RESET;
            allpass_coef   = psf_pkg::COEF_RESET;
            mismatches     = 0;
            samples_taken  = 0;
            restarts_taken = 0;
            tones_checked  = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (string_ring[i])
                string_ring[i] = '0;
            write_slot   = 0;
            comb_prev    = '0;
            lowpass_prev = '0;
            out_prev     = '0;
        endfunction

        function void write_register(logic [psf_pkg::CFG_ADDR_W-1:0] idx,
                                     logic [psf_pkg::CFG_W-1:0] value);
            case (idx)
                psf_pkg::REG_DELAY_LENGTH: delay_length = value[psf_pkg::DELAY_W-1:0];
                psf_pkg::REG_COMB_GAIN:    comb_gain    = value[psf_pkg::GAIN_W-1:0];
                psf_pkg::REG_ALLPASS_COEF: allpass_coef = value[psf_pkg::COEF_W-1:0];
                default: ;
            endcase
        endfunction

        function void accept_excitation(logic mode, logic [psf_pkg::SAMPLE_BITS-1:0] sample);
            longint excite;
            longint fed_back;
            longint comb;
            longint lowpass;
            longint coef;
            longint tone;
            longint tone_max;
            int     taps;
            int     read_slot;

            if (mode == psf_pkg::MODE_RESTART)
            begin
                clear_string();
                restarts_taken++;
                return;
            end

            excite = longint'($signed(sample));
            taps   = int'(delay_length);
            if (taps < 1)
                taps = 1;
            if (taps > psf_pkg::MAX_DELAY_DEF)
                taps = psf_pkg::MAX_DELAY_DEF;

            read_slot = (write_slot + psf_pkg::MAX_DELAY_DEF - taps)
                      % psf_pkg::MAX_DELAY_DEF;
            fed_back  = longint'(string_ring[read_slot]);

            // Coefficient products are rounded half up onto the sample grid.
            comb    = excite + ((longint'(comb_gain) * fed_back + 32768) >>> 16);
            lowpass = (comb + comb_prev + 1) >>> 1;
            coef    = (allpass_coef > psf_pkg::COEF_ONE) ? longint'(psf_pkg::COEF_ONE)
                                                         : longint'(allpass_coef);
            tone    = lowpass_prev + ((coef * (lowpass - out_prev) + 32768) >>> 16);

            tone_max = (longint'(1) <<< (psf_pkg::SAMPLE_BITS - 1)) - 1;
            if (tone > tone_max)
                tone = tone_max;
            if (tone < -tone_max - 1)
                tone = -tone_max - 1;

            string_ring[write_slot] = tone[psf_pkg::SAMPLE_BITS-1:0];
            write_slot   = (write_slot + 1) % psf_pkg::MAX_DELAY_DEF;
            comb_prev    = comb[psf_pkg::G_W-1:0];
            lowpass_prev = lowpass[psf_pkg::G_W-1:0];
            out_prev     = tone[psf_pkg::SAMPLE_BITS-1:0];
            expected_tone.push_back(tone[psf_pkg::SAMPLE_BITS-1:0]);
            samples_taken++;
        endfunction

        function void check_sample_out(logic [psf_pkg::SAMPLE_BITS-1:0] got);
            logic [psf_pkg::SAMPLE_BITS-1:0] want;

            tones_checked++;
            if (expected_tone.size() == 0)
            begin
                $error("sample_out: expected nothing, actual %0d", $signed(got));
                mismatches++;
                return;
            end
            want = expected_tone.pop_front();
            if (got !== want)
            begin
                $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
                mismatches++;
            end
        endfunction

        function int tones_pending();
            return expected_tone.size();
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plucked-string filter testbench
// Drives excitation and restart items under varying register settings and
// stream back-pressure, and checks every output sample against a predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [psf_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int LONG_STALL    = 600;
    localparam int PHASE_ITEMS   = 280;
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic [psf_pkg::CFG_W-1:0]       cfg_word_t;
    typedef logic [psf_pkg::SAMPLE_BITS-1:0] sample_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [psf_pkg::CFG_ADDR_W-1:0]    cfg_addr  = '0;
    cfg_word_t                         cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    sample_t                           s_tdata   = '0;
    logic                              s_tuser   = psf_pkg::MODE_PROCESS;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    sample_t                           m_tdata;

    psf_tb_pkg::string_tone_checker tone_sb = new();

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int stall_requests = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    plucked_string_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** plucked_string_filter: FAILED **");
            $finish;
        end
    end

    // Output side: checks results, stalls at random and serves long hold-offs.
    initial
    begin : sample_sink
        int stalls_served;
        int stall_left;

        stalls_served = 0;
        stall_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tone_sb.check_sample_out(m_tdata);
            if (stall_left == 0 && stalls_served != stall_requests)
            begin
                stall_left = LONG_STALL;
                stalls_served++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Valid stays high between back-to-back items; it only drops for a gap.
    task automatic send_item(input logic mode, input sample_t sample);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= sample;
        do
            @(posedge clk);
        while (!s_tready);
        tone_sb.accept_excitation(mode, sample);
    endtask

    // A restart gives no result, so a fixed margin follows the last output.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tone_sb.tones_pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [psf_pkg::CFG_ADDR_W-1:0] idx,
                                  input cfg_word_t value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        tone_sb.write_register(idx, value);
    endtask

    task automatic configure(input cfg_word_t delay_value,
                             input cfg_word_t gain_value,
                             input cfg_word_t coef_value);
        write_register(psf_pkg::REG_DELAY_LENGTH, delay_value);
        write_register(psf_pkg::REG_COMB_GAIN, gain_value);
        write_register(psf_pkg::REG_ALLPASS_COEF, coef_value);
        write_register(REG_UNUSED, cfg_word_t'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    initial
    begin : stimulus
        int        phase;
        int        sent_in_phase;
        int        block_len;
        int        burst_len;
        int        pick;
        cfg_word_t delay_value;
        cfg_word_t gain_value;
        cfg_word_t coef_value;
        sample_t   sample;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset register values, full-scale samples and a restart.
        send_item(psf_pkg::MODE_PROCESS, 16'h7FFF);
        send_item(psf_pkg::MODE_PROCESS, 16'h8000);
        send_item(psf_pkg::MODE_PROCESS, 16'h0000);
        send_item(psf_pkg::MODE_PROCESS, 16'hFFFF);
        send_item(psf_pkg::MODE_PROCESS, 16'h0001);
        send_item(psf_pkg::MODE_RESTART, 16'h7FFF);
        settle();

        // Zero delay acts as one; full gain and unity allpass drive saturation.
        configure({4'hF, 13'd0}, 17'h1FFFF, 17'h10000);
        repeat (6) send_item(psf_pkg::MODE_PROCESS, 16'h7FFF);
        repeat (4) send_item(psf_pkg::MODE_PROCESS, 16'h8000);
        settle();

        // Delay beyond the line length and a coefficient above one.
        configure(17'h1FFFF, 17'h00000, 17'h1FFFF);
        send_item(psf_pkg::MODE_PROCESS, 16'h5555);
        send_item(psf_pkg::MODE_PROCESS, 16'hAAAA);
        send_item(psf_pkg::MODE_RESTART, 16'h0000);
        send_item(psf_pkg::MODE_PROCESS, 16'h1234);
        settle();

        configure(17'd4096, 17'd32768, 17'd0);
        repeat (4) send_item(psf_pkg::MODE_PROCESS, sample_t'($urandom));

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 26;
                    recv_idle_pct <= 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct <= 26;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                settle();

                // Mostly short strings that ring, now and then the extremes.
                pick = $urandom_range(9);
                if (pick == 0)
                    delay_value = 17'd0;
                else if (pick == 1)
                    delay_value = 17'd4096;
                else if (pick == 2)
                    delay_value = cfg_word_t'($urandom_range(4097, 8191));
                else
                    delay_value = cfg_word_t'($urandom_range(1, 40));
                // Bits above the register width carry noise.
                delay_value = (cfg_word_t'($urandom) << psf_pkg::DELAY_W) | delay_value;

                pick = $urandom_range(9);
                if (pick == 0)
                    gain_value = 17'd0;
                else if (pick == 1)
                    gain_value = 17'd65535;
                else if (pick < 5)
                    gain_value = cfg_word_t'($urandom_range(65535));
                else
                    gain_value = cfg_word_t'($urandom_range(45000, 65535));
                gain_value[psf_pkg::GAIN_W] = 1'($urandom);

                pick = $urandom_range(9);
                if (pick == 0)
                    coef_value = 17'd0;
                else if (pick == 1)
                    coef_value = psf_pkg::COEF_ONE;
                else if (pick == 2)
                    coef_value = cfg_word_t'($urandom_range(65537, 131071));
                else
                    coef_value = cfg_word_t'($urandom_range(65536));

                configure(delay_value, gain_value, coef_value);

                // One long output hold-off while the sender keeps offering.
                if (phase == 2 && sent_in_phase == 0)
                    stall_requests <= stall_requests + 1;

                // A pluck: noise burst, then mostly quiet input while it rings.
                block_len = $urandom_range(20, 50);
                burst_len = $urandom_range(1, 40);
                if ($urandom_range(1) == 1)
                    send_item(psf_pkg::MODE_RESTART, sample_t'($urandom));
                for (int i = 0; i < block_len; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                    begin
                        send_item(psf_pkg::MODE_RESTART, sample_t'($urandom));
                    end
                    else
                    begin
                        if (i < burst_len || pick < 20)
                            sample = sample_t'($urandom);
                        else if (pick < 26)
                            sample = (pick[0]) ? 16'h7FFF : 16'h8000;
                        else if (pick < 60)
                            sample = sample_t'(int'($urandom_range(64)) - 32);
                        else
                            sample = '0;
                        send_item(psf_pkg::MODE_PROCESS, sample);
                    end
                end
                sent_in_phase += block_len;
            end
        end

        settle();
        $display("Covered %0d samples and %0d restarts over %0d register settings,",
                 tone_sb.samples_taken, tone_sb.restarts_taken, settings_used);
        $display("three idling profiles and one long output hold-off.");
        if (tone_sb.mismatches == 0 && tone_sb.tones_pending() == 0)
            $display("** plucked_string_filter: PASSED **");
        else
            $display("** plucked_string_filter: FAILED **");
        $finish;
    end

endmodule
